// ----- rtl/fcsg_pkg.sv -----
// Shared constants for the filled circle span generator.
package fcsg_pkg;

  localparam int RADIUS_BITS_DEFAULT = 12;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int COORD_W = 15;
  localparam int SPAN_W = 16;
  localparam int RADIUS_CFG_W = 12;
  localparam int QUEUE_DEPTH = 2;

  // Step limit 1414*i <= 1000*r
  localparam int STEP_SCALE = 1414;
  localparam int RADIUS_SCALE = 1000;
  localparam int SCALE_EXTRA_W = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 2'd2;

endpackage

// ----- rtl/fcsg_if.sv -----
// Handshake channels for step transactions and span transactions.
interface fcsg_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

interface fcsg_span_if;
  logic valid;
  logic ready;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_left;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_right;
  logic signed [fcsg_pkg::SPAN_W-1:0] span_row;
  logic last_of_step;
  logic last_of_circle;

  modport source(output valid, output span_left, output span_right, output span_row,
                 output last_of_step, output last_of_circle, input ready);
  modport sink(input valid, input span_left, input span_right, input span_row,
               input last_of_step, input last_of_circle, output ready);
endinterface

// ----- rtl/fcsg_queue.sv -----
// Small FIFO between the step front end and the span back end.
module fcsg_queue #(
  parameter int WIDTH = 13,
  parameter int DEPTH = fcsg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/fcsg_front.sv -----
// Step front end: tracks the step index and queues steps that produce spans.
module fcsg_front #(
  parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  fcsg_step_if.sink              step_in,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic                   queue_full,
  output logic                   push,
  output logic [RADIUS_BITS:0]   push_data
);

  localparam int CW = RADIUS_BITS + fcsg_pkg::SCALE_EXTRA_W;

  logic [RADIUS_BITS-1:0] step_index;
  logic [RADIUS_BITS-1:0] step_index_next;
  logic                   finished;
  logic                   finished_next;
  logic [RADIUS_BITS-1:0] cur_i;
  logic                   cur_fin;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          scaled_i;
  logic [CW-1:0]          scaled_next;
  logic                   over;
  logic                   last;
  logic                   accept;

  assign step_in.ready = !queue_full;
  assign accept = step_in.valid && step_in.ready;

  assign cur_i = step_in.restart ? '0 : step_index;
  assign cur_fin = step_in.restart ? 1'b0 : finished;
  assign limit = CW'(radius) * CW'(fcsg_pkg::RADIUS_SCALE);
  assign scaled_i = CW'(cur_i) * CW'(fcsg_pkg::STEP_SCALE);
  assign scaled_next = scaled_i + CW'(fcsg_pkg::STEP_SCALE);
  assign over = scaled_i > limit;
  assign last = scaled_next > limit;

  assign push = accept && !cur_fin && !over;
  assign push_data = {last, cur_i};

  always_comb begin
    step_index_next = step_index;
    finished_next = finished;
    if (accept) begin
      step_index_next = cur_i;
      finished_next = cur_fin;
      if (!cur_fin) begin
        if (over) begin
          finished_next = 1'b1;
        end else if (last) begin
          finished_next = 1'b1;
          step_index_next = '0;
        end else begin
          step_index_next = cur_i + RADIUS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      finished <= 1'b1;
    end else begin
      step_index <= step_index_next;
      finished <= finished_next;
    end
  end

endmodule

// ----- rtl/fcsg_back.sv -----
// Span back end: squares, iterative square root and four-span emission.
module fcsg_back #(
  parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [RADIUS_BITS-1:0]                radius,
  input  logic signed [fcsg_pkg::COORD_W-1:0]   center_x,
  input  logic signed [fcsg_pkg::COORD_W-1:0]   center_y,
  input  logic                                  queue_not_empty,
  input  logic [RADIUS_BITS:0]                  pop_data,
  output logic                                  pop,
  fcsg_span_if.source                           span_out
);

  localparam int SW = 2 * RADIUS_BITS;
  localparam int OW = fcsg_pkg::SPAN_W;
  localparam logic [SW-1:0] BIT_INIT = SW'(1) << (SW - 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]             state;
  logic [RADIUS_BITS-1:0] cur_i;
  logic                   cur_last;
  logic [SW-1:0]          sq_r;
  logic [SW-1:0]          sq_i;
  logic [SW-1:0]          rem;
  logic [SW-1:0]          res;
  logic [SW-1:0]          bitv;
  logic [SW-1:0]          trial;
  logic [SW-1:0]          rem_next;
  logic [SW-1:0]          res_next;
  logic [1:0]             phase;
  logic                   load;
  logic [OW-1:0]          cx16;
  logic [OW-1:0]          cy16;
  logic [OW-1:0]          i16;
  logic [OW-1:0]          j16;
  logic [OW-1:0]          half;
  logic [OW-1:0]          row;

  assign pop = (state == ST_IDLE) && queue_not_empty;
  assign load = (state == ST_EMIT) && (!span_out.valid || span_out.ready);

  assign trial = res + bitv;
  always_comb begin
    if (rem >= trial) begin
      rem_next = rem - trial;
      res_next = (res >> 1) + bitv;
    end else begin
      rem_next = rem;
      res_next = res >> 1;
    end
  end

  assign cx16 = {center_x[fcsg_pkg::COORD_W-1], center_x};
  assign cy16 = {center_y[fcsg_pkg::COORD_W-1], center_y};
  assign i16 = OW'(cur_i);
  assign j16 = OW'(res[RADIUS_BITS-1:0]);

  always_comb begin
    case (phase)
      2'd0: begin
        half = i16;
        row = cy16 + j16;
      end
      2'd1: begin
        half = j16;
        row = cy16 + i16;
      end
      2'd2: begin
        half = j16;
        row = cy16 - i16;
      end
      default: begin
        half = i16;
        row = cy16 - j16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_i <= pop_data[RADIUS_BITS-1:0];
      cur_last <= pop_data[RADIUS_BITS];
    end
    if (state == ST_SQUARE) begin
      sq_r <= SW'(radius) * SW'(radius);
      sq_i <= SW'(cur_i) * SW'(cur_i);
    end
    if (state == ST_DIFF) begin
      rem <= sq_r - sq_i;
      res <= '0;
      bitv <= BIT_INIT;
    end else if (state == ST_ROOT) begin
      rem <= rem_next;
      res <= res_next;
      bitv <= bitv >> 2;
    end
    if (load) begin
      span_out.span_left <= cx16 - half;
      span_out.span_right <= cx16 + half;
      span_out.span_row <= row;
      span_out.last_of_step <= (phase == 2'd3);
      span_out.last_of_circle <= (phase == 2'd3) && cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      span_out.valid <= 1'b0;
    end else begin
      if (load) begin
        span_out.valid <= 1'b1;
      end else if (span_out.ready) begin
        span_out.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (queue_not_empty) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (bitv[0]) begin
            state <= ST_EMIT;
            phase <= '0;
          end
        end
        ST_EMIT: begin
          if (load) begin
            phase <= phase + 2'd1;
            if (phase == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/filled_circle_span_generator.sv -----
// The step rate is limited by the square root, which resolves one result bit per cycle,
// and by the four span beats through the output register, which wait on span_out.ready;
// the back end pops a new step only after the last span of the earlier one is loaded.
// A two-entry queue lets steps be taken while the back end works on an earlier one.
// Reset (synchronous, active high) clears the configuration and control registers, empties
// the queue and leaves the block finished until a restart transaction arrives.
module filled_circle_span_generator #(
  parameter int RADIUS_BITS = fcsg_pkg::RADIUS_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [fcsg_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [fcsg_pkg::CFG_DATA_W-1:0]     wr_data,
  fcsg_step_if.sink                           step_in,
  fcsg_span_if.source                         span_out
);

  logic signed [fcsg_pkg::COORD_W-1:0] center_x;
  logic signed [fcsg_pkg::COORD_W-1:0] center_y;
  logic [RADIUS_BITS-1:0]              radius;
  logic [15:0]                         radius_wide;
  logic                                q_push;
  logic [RADIUS_BITS:0]                q_push_data;
  logic                                q_pop;
  logic [RADIUS_BITS:0]                q_pop_data;
  logic                                q_full;
  logic                                q_not_empty;

  assign radius_wide = 16'(wr_data[fcsg_pkg::RADIUS_CFG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius <= '0;
    end else if (wr_en) begin
      case (wr_index)
        fcsg_pkg::REG_CENTER_X: center_x <= wr_data;
        fcsg_pkg::REG_CENTER_Y: center_y <= wr_data;
        fcsg_pkg::REG_RADIUS: radius <= radius_wide[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  fcsg_front #(.RADIUS_BITS(RADIUS_BITS)) u_front (
    .clk(clk),
    .rst(rst),
    .step_in(step_in),
    .radius(radius),
    .queue_full(q_full),
    .push(q_push),
    .push_data(q_push_data)
  );

  fcsg_queue #(.WIDTH(RADIUS_BITS + 1), .DEPTH(fcsg_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_push_data),
    .pop(q_pop),
    .pop_data(q_pop_data),
    .full(q_full),
    .not_empty(q_not_empty)
  );

  fcsg_back #(.RADIUS_BITS(RADIUS_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .radius(radius),
    .center_x(center_x),
    .center_y(center_y),
    .queue_not_empty(q_not_empty),
    .pop_data(q_pop_data),
    .pop(q_pop),
    .span_out(span_out)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full step queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_not_empty)
    else $error("pop from empty step queue");

  a_circle_end_on_step_end: assert property (@(posedge clk) disable iff (rst)
    (span_out.valid && span_out.last_of_circle) |-> span_out.last_of_step)
    else $error("last_of_circle without last_of_step");

  a_push_after_restart_pops: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_not_empty)
    else $error("queued step lost");

endmodule
